/* sv/her2_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// her2_pkg: shared constants and types for the Hermitian rank-2 update
// Register indexes, status codes and default parameter values.
// ----------------------------------------------------------------------------
package her2_pkg;

   localparam int MAX_N_DEF     = 64;
   localparam int DATA_W_DEF    = 32;
   localparam int FRAC_BITS_DEF = 16;

   localparam int IDX_W   = 6;
   localparam int FIELD_W = 32;
   localparam int NREG_W  = 7;

   typedef enum logic [1:0] {
      REG_LOWER   = 2'd0,
      REG_SIZE_N  = 2'd1,
      REG_ALPHA_R = 2'd2,
      REG_ALPHA_I = 2'd3
   } reg_idx_type;

   typedef enum logic [1:0] {
      ST_UPDATED   = 2'd0,
      ST_PASSED    = 2'd1,
      ST_RANGE     = 2'd2,
      ST_SATURATED = 2'd3
   } status_type;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_UPDATE = 1'b1;

endpackage

/* sv/hermitian_rank2_update.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermitian_rank2_update: streaming element-wise ZHER2-style update
// A(r,c) += alpha*x[r]*conj(y[c]) + conj(alpha)*y[r]*conj(x[c]), Q format.
// ----------------------------------------------------------------------------
//  channel | dir | handshake           | payload
//  req     | in  | req_tvalid/tready   | req_tdata, req_tuser = cmd
//  rsp     | out | rsp_tvalid/tready   | rsp_tdata, rsp_tuser = status
//  csr     | in  | csr_valid/ready     | csr_index, csr_data
//
//  One item per cycle while rsp is not stalled; an update item passes the
//  store read at the accepting edge, two multiply and two scale stages,
//  then the output register.
//  Load items write both stores at their accepting edge and give no result;
//  an update accepted on any later edge reads the new entry.
//  Synchronous active-high reset clears valid bits and config registers, not stores or data registers.
//  rsp stall stops the whole pipeline; req_tready follows rsp readiness.
// ----------------------------------------------------------------------------
module hermitian_rank2_update #(
   parameter int MAX_N     = her2_pkg::MAX_N_DEF,
   parameter int DATA_W    = her2_pkg::DATA_W_DEF,
   parameter int FRAC_BITS = her2_pkg::FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // vec_index[5:0], x_re, x_im, y_re, y_im, row_index, col_index, a_re, a_im
   input  logic [215:0] req_tdata,
   // cmd
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // new_re, new_im, out_row, out_col
   output logic [79:0] rsp_tdata,
   // status
   output logic [1:0]  rsp_tuser,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);
   localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
   localparam int PW = 2 * DATA_W + 2;
   localparam int SW = DATA_W + 3;
   localparam int NS = 5;

   typedef logic signed [DATA_W-1:0] d_type;

   // configuration
   logic              lower_ff;
   logic [6:0]        size_ff;
   d_type             alr_ff, ali_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         lower_ff <= 1'b0; size_ff <= '0; alr_ff <= '0; ali_ff <= '0;
      end else if (csr_valid) begin
         unique case (her2_pkg::reg_idx_type'(csr_index))
            her2_pkg::REG_LOWER:   lower_ff <= csr_data[0];
            her2_pkg::REG_SIZE_N:  size_ff  <= csr_data[6:0];
            her2_pkg::REG_ALPHA_R: alr_ff   <= d_type'(csr_data[DATA_W-1:0]);
            her2_pkg::REG_ALPHA_I: ali_ff   <= d_type'(csr_data[DATA_W-1:0]);
            default: ;
         endcase
      end
   end

   // field unpack
   logic [5:0] vidx, ridx, cidx;
   d_type xr, xi, yr, yi, ar, ai;
   assign vidx = req_tdata[5:0];
   assign xr   = d_type'(req_tdata[6+:DATA_W]);
   assign xi   = d_type'(req_tdata[38+:DATA_W]);
   assign yr   = d_type'(req_tdata[70+:DATA_W]);
   assign yi   = d_type'(req_tdata[102+:DATA_W]);
   assign ridx = req_tdata[139:134];
   assign cidx = req_tdata[145:140];
   assign ar   = d_type'(req_tdata[146+:DATA_W]);
   assign ai   = d_type'(req_tdata[178+:DATA_W]);

   // pipeline enable: advance unless the output is held
   logic adv;
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;
   logic acc;
   assign acc = req_tvalid && req_tready;

   // stores: {re, im} for x and y
   logic [2*DATA_W-1:0] xmem [MAX_N];
   logic [2*DATA_W-1:0] ymem [MAX_N];
   logic [2*DATA_W-1:0] xr_q, xc_q, yr_q, yc_q;
   logic wr_ok;
   assign wr_ok = acc && (req_tuser == her2_pkg::CMD_LOAD) && ({26'd0, vidx} < MAX_N);
   always_ff @(posedge clock) begin
      if (wr_ok) begin
         xmem[AW'(vidx)] <= {xr, xi};
         ymem[AW'(vidx)] <= {yr, yi};
      end
   end
   // read ports (registered), row and column entries
   always_ff @(posedge clock) begin
      if (adv) begin
         xr_q <= xmem[AW'(ridx)]; yr_q <= ymem[AW'(ridx)];
         xc_q <= xmem[AW'(cidx)]; yc_q <= ymem[AW'(cidx)];
      end
   end

   // stage 0 control/payload
   typedef struct packed {
      logic       vld;
      logic       upd;
      logic [1:0] st;
      logic [5:0] r, c;
      logic       diag;
      logic [DATA_W-1:0] are, aim;
   } ctl_type;

   logic [6:0] n_eff;
   assign n_eff = ({25'd0, size_ff} > MAX_N) ? 7'(MAX_N) : size_ff;
   ctl_type c0_in;
   always_comb begin
      c0_in      = '0;
      c0_in.vld  = acc && (req_tuser == her2_pkg::CMD_UPDATE);
      c0_in.r    = ridx; c0_in.c = cidx;
      c0_in.are  = ar;   c0_in.aim = ai;
      c0_in.diag = (ridx == cidx);
      if (n_eff == 0 || (alr_ff == 0 && ali_ff == 0)) c0_in.st = her2_pkg::ST_PASSED;
      else if ({1'b0, ridx} >= n_eff || {1'b0, cidx} >= n_eff) c0_in.st = her2_pkg::ST_RANGE;
      else if (lower_ff ? (cidx > ridx) : (cidx < ridx)) c0_in.st = her2_pkg::ST_PASSED;
      else begin c0_in.st = her2_pkg::ST_UPDATED; c0_in.upd = 1'b1; end
   end

   ctl_type c_ff [NS];
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) c_ff[i].vld <= 1'b0;
      end else if (adv) begin
         c_ff[0] <= c0_in;
         for (int i = 1; i < NS; i++) c_ff[i] <= c_ff[i-1];
      end
   end

   // split the stored pairs
   d_type x_r_re, x_r_im, y_r_re, y_r_im, x_c_re, x_c_im, y_c_re, y_c_im;
   always_comb begin
      {x_r_re, x_r_im} = xr_q;
      {y_r_re, y_r_im} = yr_q;
      {x_c_re, x_c_im} = xc_q;
      {y_c_re, y_c_im} = yc_q;
   end

   // scale a product sum by FRAC_BITS with floor, saturate
   function automatic d_type scl(input logic signed [PW-1:0] v, output logic s);
      logic signed [PW-1:0] t;
      t = v >>> FRAC_BITS;
      if (t > PW'((64'sd1 <<< (DATA_W-1)) - 1)) begin
         s = 1'b1; return d_type'((64'sd1 <<< (DATA_W-1)) - 1);
      end else if (t < -PW'(64'sd1 <<< (DATA_W-1))) begin
         s = 1'b1; return d_type'(-(64'sd1 <<< (DATA_W-1)));
      end
      s = 1'b0; return d_type'(t);
   endfunction

   // stage 1: products for ty = alpha*conj(yc), tx = conj(alpha)*conj(xc)
   logic signed [2*DATA_W-1:0] m1_ff [8];
   d_type xrr_ff, xri_ff, yrr_ff, yri_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m1_ff[0] <= alr_ff * y_c_re;  m1_ff[1] <= ali_ff * y_c_im; // re = +m0 + m1
         m1_ff[2] <= ali_ff * y_c_re;  m1_ff[3] <= alr_ff * y_c_im; // im = m2 - m3
         m1_ff[4] <= alr_ff * x_c_re;  m1_ff[5] <= ali_ff * x_c_im; // re = m4 - m5
         m1_ff[6] <= alr_ff * x_c_im;  m1_ff[7] <= ali_ff * x_c_re; // im = -m6 - m7
         xrr_ff <= x_r_re; xri_ff <= x_r_im; yrr_ff <= y_r_re; yri_ff <= y_r_im;
      end
   end

   // stage 2: scale tx, ty
   d_type tyr_ff, tyi_ff, txr_ff, txi_ff;
   d_type xrr2_ff, xri2_ff, yrr2_ff, yri2_ff;
   logic  s01_ff;
   always_ff @(posedge clock) begin
      logic a, b, c, d;
      if (adv) begin
         tyr_ff <= scl(PW'(m1_ff[0]) + PW'(m1_ff[1]), a);
         tyi_ff <= scl(PW'(m1_ff[2]) - PW'(m1_ff[3]), b);
         txr_ff <= scl(PW'(m1_ff[4]) - PW'(m1_ff[5]), c);
         txi_ff <= scl(-PW'(m1_ff[6]) - PW'(m1_ff[7]), d);
         s01_ff <= a | b | c | d;
         xrr2_ff <= xrr_ff; xri2_ff <= xri_ff; yrr2_ff <= yrr_ff; yri2_ff <= yri_ff;
      end
   end

   // stage 3: second products
   logic signed [2*DATA_W-1:0] m3_ff [8];
   logic s01b_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         m3_ff[0] <= xrr2_ff * tyr_ff; m3_ff[1] <= xri2_ff * tyi_ff;
         m3_ff[2] <= xrr2_ff * tyi_ff; m3_ff[3] <= xri2_ff * tyr_ff;
         m3_ff[4] <= yrr2_ff * txr_ff; m3_ff[5] <= yri2_ff * txi_ff;
         m3_ff[6] <= yrr2_ff * txi_ff; m3_ff[7] <= yri2_ff * txr_ff;
         s01b_ff <= s01_ff;
      end
   end

   // stage 4: scale p and q
   d_type pr_ff, pi_ff, qr_ff, qi_ff;
   logic  sre_ff, sim_ff;
   always_ff @(posedge clock) begin
      logic a, b, c, d;
      if (adv) begin
         pr_ff <= scl(PW'(m3_ff[0]) - PW'(m3_ff[1]), a);
         pi_ff <= scl(PW'(m3_ff[2]) + PW'(m3_ff[3]), b);
         qr_ff <= scl(PW'(m3_ff[4]) - PW'(m3_ff[5]), c);
         qi_ff <= scl(PW'(m3_ff[6]) + PW'(m3_ff[7]), d);
         sre_ff <= s01b_ff | a | c;
         sim_ff <= b | d;
      end
   end

   // final sums and output register
   localparam logic signed [SW-1:0] DMAX = SW'((64'sd1 <<< (DATA_W-1)) - 1);
   localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);
   logic signed [SW-1:0] sr, si;
   d_type nr, ni;
   logic  sat;
   ctl_type cl;
   always_comb begin
      cl  = c_ff[NS-1];
      sr  = SW'(d_type'(cl.are)) + SW'(pr_ff) + SW'(qr_ff);
      si  = SW'(d_type'(cl.aim)) + SW'(pi_ff) + SW'(qi_ff);
      sat = sre_ff;
      nr  = d_type'(cl.are); ni = d_type'(cl.aim);
      if (cl.upd) begin
         if (sr > DMAX) begin nr = d_type'(DMAX); sat = 1'b1; end
         else if (sr < DMIN) begin nr = d_type'(DMIN); sat = 1'b1; end
         else nr = d_type'(sr);
         if (cl.diag) ni = '0;
         else begin
            sat = sat | sim_ff;
            if (si > DMAX) begin ni = d_type'(DMAX); sat = 1'b1; end
            else if (si < DMIN) begin ni = d_type'(DMIN); sat = 1'b1; end
            else ni = d_type'(si);
         end
      end
   end

   logic        ov_ff;
   logic [79:0] od_ff;
   logic [1:0]  os_ff;
   always_ff @(posedge clock) begin
      if (reset) ov_ff <= 1'b0;
      else if (adv) ov_ff <= cl.vld;
      if (adv) begin
         od_ff <= {4'd0, cl.c, cl.r, 32'(signed'(ni)), 32'(signed'(nr))};
         os_ff <= cl.upd ? (sat ? her2_pkg::ST_SATURATED : her2_pkg::ST_UPDATED) : cl.st;
      end
   end
   assign rsp_tvalid = ov_ff;
   assign rsp_tdata  = od_ff;
   assign rsp_tuser  = os_ff;
endmodule

/* sv/her2_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// her2_checker: port-level checks for hermitian_rank2_update
// Watches the result channel and the input handshake.
// ----------------------------------------------------------------------------
module her2_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);
   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");
   // input ready whenever the output register is empty
   a_rdy: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input blocked with empty output");
   // diagonal update has zero imaginary part
   a_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == her2_pkg::ST_UPDATED && rsp_tdata[75:70] == rsp_tdata[69:64]
      |-> rsp_tdata[63:32] == 32'd0)
      else $error("diagonal imaginary not zero");
   // no result out of reset
   a_rst: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result after reset");
endmodule

bind hermitian_rank2_update her2_checker u_her2_checker (
   .clock(clock), .reset(reset), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
   .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser));
